// ===== rtl/swm_pkg.sv =====
// Package for the sliding window maximum block.
// Holds the controller state type, the command and status bundles and the register width.
// No dependencies; used by swm_ctrl, swm_dpath and sliding_window_max.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    localparam int CFG_W = 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FRONT_RD,
        S_FRONT_CHK,
        S_BACK_RD,
        S_BACK_CHK,
        S_PUSH,
        S_OUT_RD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_front;
        logic drop_front;
        logic rd_back;
        logic drop_back;
        logic push;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic front_stale;
        logic back_smaller;
        logic emit;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/swm_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// No dependencies; used for both copies of the deque storage.
`timescale 1ns / 1ps
`default_nettype none

module swm_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 64
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]                              i_wdata,
    input  wire logic                                          i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic      [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/swm_ctrl.sv =====
// Controller state machine for the sliding window maximum block.
// Depends on swm_pkg; drives the command bundle of swm_dpath from its status bundle.
`timescale 1ns / 1ps
`default_nettype none

module swm_ctrl
    import swm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  t_status      i_status,
    output logic         o_stall,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_FRONT_RD;
                end
            end
            S_FRONT_RD:  n_state = S_FRONT_CHK;
            S_FRONT_CHK: begin
                n_state = i_status.front_stale ? S_FRONT_RD : S_BACK_RD;
            end
            S_BACK_RD:   n_state = S_BACK_CHK;
            S_BACK_CHK: begin
                n_state = i_status.back_smaller ? S_BACK_RD : S_PUSH;
            end
            S_PUSH:      n_state = S_OUT_RD;
            S_OUT_RD:    n_state = S_OUT;
            S_OUT: begin
                if (!i_status.emit || i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            S_FRONT_RD:  o_cmd.rd_front   = 1'b1;
            S_FRONT_CHK: o_cmd.drop_front = i_status.front_stale;
            S_BACK_RD:   o_cmd.rd_back    = 1'b1;
            S_BACK_CHK:  o_cmd.drop_back  = i_status.back_smaller;
            S_PUSH:      o_cmd.push       = 1'b1;
            S_OUT_RD:    o_cmd.rd_front   = 1'b1;
            S_OUT:       o_cmd.load_out   = i_status.emit && i_status.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/swm_dpath.sv =====
// Datapath of the sliding window maximum block: deque pointers, counters and result register.
// Depends on swm_pkg and swm_ram; keeps two mirrored copies of the deque storage.
`timescale 1ns / 1ps
`default_nettype none

module swm_dpath
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_window_size_we,
    input  wire logic        [CFG_W-1:0]        i_window_size,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                           i_start_req,
    input  wire logic                           i_stall,
    input  t_cmd                                i_cmd,
    output t_status                             o_status,
    output logic                                o_valid,
    output logic signed [SAMPLE_WIDTH-1:0]      o_window_max
);

    localparam int HEAD_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
    localparam int POS_W   = $clog2(2 * WINDOW_MAX);
    localparam int SUM_W   = CNT_W + 1;
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int ENT_W   = SAMPLE_WIDTH + POS_W;
    localparam int POS_MOD = 2 * WINDOW_MAX;

    logic [CFG_W-1:0]               r_window_size;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic [HEAD_W-1:0]              r_head;
    logic [CNT_W-1:0]               r_count;
    logic [POS_W-1:0]               r_pos;
    logic [CNT_W-1:0]               r_seen;
    logic                           r_emit;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_window_max;

    logic [CNT_W-1:0]               w_k;
    logic [ENT_W-1:0]               w_front_ent;
    logic [ENT_W-1:0]               w_back_ent;
    logic [ENT_W-1:0]               w_push_ent;
    logic signed [SAMPLE_WIDTH-1:0] w_front_val;
    logic signed [SAMPLE_WIDTH-1:0] w_back_val;
    logic [POS_W-1:0]               w_front_pos;
    logic [POS_W:0]                 w_age_sum;
    logic [POS_W-1:0]               w_age;
    logic [HEAD_W-1:0]              w_head_inc;
    logic [SUM_W-1:0]               w_back_sum;
    logic [SUM_W-1:0]               w_tail_sum;
    logic [HEAD_W-1:0]              w_back_slot;
    logic [HEAD_W-1:0]              w_tail_slot;
    logic [HEAD_W-1:0]              w_push_slot;
    logic                           w_full;
    logic [CNT_W-1:0]               w_seen_next;
    logic                           w_out_free;

    always_comb begin
        if (r_window_size == '0) begin
            w_k = CNT_W'(1);
        end else if (CMP_W'(r_window_size) > CMP_W'(WINDOW_MAX)) begin
            w_k = CNT_W'(WINDOW_MAX);
        end else begin
            w_k = CNT_W'(r_window_size);
        end
    end

    assign w_head_inc = (r_head == HEAD_W'(WINDOW_MAX - 1)) ? '0 : r_head + 1'b1;

    assign w_back_sum  = SUM_W'(r_head) + SUM_W'(r_count) - 1'b1;
    assign w_tail_sum  = SUM_W'(r_head) + SUM_W'(r_count);
    assign w_back_slot = (w_back_sum >= SUM_W'(WINDOW_MAX))
                       ? HEAD_W'(w_back_sum - SUM_W'(WINDOW_MAX)) : HEAD_W'(w_back_sum);
    assign w_tail_slot = (w_tail_sum >= SUM_W'(WINDOW_MAX))
                       ? HEAD_W'(w_tail_sum - SUM_W'(WINDOW_MAX)) : HEAD_W'(w_tail_sum);
    assign w_full      = (r_count == CNT_W'(WINDOW_MAX));
    assign w_push_slot = w_full ? r_head : w_tail_slot;
    assign w_push_ent  = {r_sample, r_pos};

    swm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (WINDOW_MAX)
    ) u_front_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (w_push_slot),
        .i_wdata (w_push_ent),
        .i_re    (i_cmd.rd_front),
        .i_raddr (r_head),
        .o_rdata (w_front_ent)
    );

    swm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (WINDOW_MAX)
    ) u_back_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (w_push_slot),
        .i_wdata (w_push_ent),
        .i_re    (i_cmd.rd_back),
        .i_raddr (w_back_slot),
        .o_rdata (w_back_ent)
    );

    assign w_front_val = w_front_ent[ENT_W-1:POS_W];
    assign w_front_pos = w_front_ent[POS_W-1:0];
    assign w_back_val  = w_back_ent[ENT_W-1:POS_W];

    assign w_age_sum = (POS_W + 1)'(r_pos) - (POS_W + 1)'(w_front_pos)
                     + ((r_pos < w_front_pos) ? (POS_W + 1)'(POS_MOD) : '0);
    assign w_age     = w_age_sum[POS_W-1:0];

    assign w_seen_next = (r_seen < CNT_W'(WINDOW_MAX)) ? r_seen + 1'b1 : r_seen;
    assign w_out_free  = !r_out_valid || !i_stall;

    assign o_status.front_stale  = (r_count != '0) && (w_age >= POS_W'(w_k));
    assign o_status.back_smaller = (r_count != '0) && (w_back_val < r_sample);
    assign o_status.emit         = r_emit;
    assign o_status.out_free     = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= CFG_W'(1);
            r_head        <= '0;
            r_count       <= '0;
            r_pos         <= '0;
            r_seen        <= '0;
            r_emit        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_window_size_we) begin
                r_window_size <= i_window_size;
            end
            if (i_cmd.load && i_start_req) begin
                r_head  <= '0;
                r_count <= '0;
                r_pos   <= '0;
                r_seen  <= '0;
            end
            if (i_cmd.drop_front) begin
                r_head  <= w_head_inc;
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.drop_back) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.push) begin
                if (w_full) begin
                    r_head <= w_head_inc;
                end else begin
                    r_count <= r_count + 1'b1;
                end
                r_pos  <= (r_pos == POS_W'(POS_MOD - 1)) ? '0 : r_pos + 1'b1;
                r_seen <= w_seen_next;
                r_emit <= (w_seen_next >= w_k);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
        if (i_cmd.load_out) begin
            r_window_max <= w_front_val;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_window_max = r_window_max;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(WINDOW_MAX))
        else $error("deque count exceeds window capacity");

    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> (r_count != '0))
        else $error("deque empty right after a push");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("result register not valid after load");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !i_cmd.load_out)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== rtl/sliding_window_max.sv =====
// Top level of the sliding window maximum block: running maximum over the last K samples.
// Depends on swm_pkg, swm_ctrl and swm_dpath (which holds two swm_ram instances).
//
//   Channel   Direction  Handshake             Beat contents
//   input     in         i_valid / o_stall     i_sample, i_start_req
//   output    out        o_valid / i_stall     o_window_max
//   config    in         i_window_size_we      i_window_size
//
// An accepted sample takes front read/check steps, dropping aged-out front entries, then back
// read/check steps, popping smaller back entries, then push, output read and output states.
// Each deque step reads, then checks, since each storage copy has one registered read port.
// Reset is synchronous and clears all control state; the deque storage needs no clearing.
// A finished result waits in the output register while the next sample is processed; the
// block holds its last state only when a second result is ready before the first is taken.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_max
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_window_size_we,
    input  wire logic        [CFG_W-1:0]        i_window_size,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                           i_start_req,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      o_window_max
);

    t_cmd    w_cmd;
    t_status w_status;

    swm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_stall  (o_stall),
        .o_cmd    (w_cmd)
    );

    swm_dpath #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_window_size_we (i_window_size_we),
        .i_window_size    (i_window_size),
        .i_sample         (i_sample),
        .i_start_req      (i_start_req),
        .i_stall          (i_stall),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_valid          (o_valid),
        .o_window_max     (o_window_max)
    );

endmodule

`default_nettype wire
